FILE: rtl/cosol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_pkg
// Shared types and constants for the count-ordered self-organizing list.
// ----------------------------------------------------------------------------
package cosol_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int FILL_W     = $clog2(LIST_DEPTH + 1);
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_BACK  = 3'd0,
        ACT_INS_FRONT = 3'd1,
        ACT_REM_FRONT = 3'd2,
        ACT_REM_BACK  = 3'd3,
        ACT_READ      = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic place;
    } dp_cmd_t;

    typedef struct packed {
        logic read_ok;
        logic move_more;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: rtl/cosol_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_ctrl
// Sequencer: accepts a beat, runs the action, then walks a read entry forward.
// ----------------------------------------------------------------------------
module cosol_ctrl
    import cosol_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !dp_status.out_busy)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = dp_status.read_ok ? S_MOVE : S_IDLE;
            end
            S_MOVE:
            begin
                if (!dp_status.move_more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        dp_cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = !dp_status.out_busy;
                dp_cmd.load = in_valid && !dp_status.out_busy;
            end
            S_EXEC:
            begin
                dp_cmd.exec = 1'b1;
            end
            S_MOVE:
            begin
                dp_cmd.step  = dp_status.move_more;
                dp_cmd.place = !dp_status.move_more;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/cosol_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosol_dpath
// Entry row, fill level, bubble index and result register.
// ----------------------------------------------------------------------------
module cosol_dpath
    import cosol_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    input  logic [ACTION_W-1:0]   action,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [POS_W-1:0]      position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] read_value,
    output logic [STATUS_W-1:0]   status,
    output logic [OCC_W-1:0]      occupancy
);

    logic [VALUE_BITS-1:0] vals_reg [LIST_DEPTH];
    logic [VALUE_BITS-1:0] vals_next [LIST_DEPTH];
    logic [COUNT_BITS-1:0] cnts_reg [LIST_DEPTH];
    logic [COUNT_BITS-1:0] cnts_next [LIST_DEPTH];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    action_t               op_reg;
    logic [VALUE_BITS-1:0] nv_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [VALUE_BITS-1:0] hold_val_reg;
    logic [VALUE_BITS-1:0] hold_val_next;
    logic [COUNT_BITS-1:0] hold_cnt_reg;
    logic [COUNT_BITS-1:0] hold_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] rv_reg;
    logic [VALUE_BITS-1:0] rv_next;
    status_t               st_reg;
    status_t               st_next;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;

    logic                  full;
    logic                  empty;
    logic                  pos_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_val;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [IDX_W-1:0]      back_idx;

    assign full     = (fill_reg == FILL_W'(LIST_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pos_ok   = (FILL_W'(pos_reg) < fill_reg);
    assign back_idx = fill_reg[IDX_W-1:0];
    assign rd_addr  = dp_cmd.exec ? IDX_W'(pos_reg) : idx_reg - IDX_W'(1);
    assign rd_val   = vals_reg[rd_addr];
    assign rd_cnt   = cnts_reg[rd_addr];

    assign dp_status.read_ok   = (op_reg == ACT_READ) && pos_ok;
    assign dp_status.move_more = (idx_reg != '0) && (hold_cnt_reg > rd_cnt);
    assign dp_status.out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            vals_next[i] = vals_reg[i];
            cnts_next[i] = cnts_reg[i];
        end
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        hold_val_next  = hold_val_reg;
        hold_cnt_next  = hold_cnt_reg;
        rv_next        = '0;
        st_next        = ST_OK;

        if (dp_cmd.exec)
        begin
            case (op_reg)
                ACT_INS_BACK:
                begin
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        vals_next[back_idx] = nv_reg;
                        cnts_next[back_idx] = '0;
                        fill_next           = fill_reg + FILL_W'(1);
                    end
                end
                ACT_INS_FRONT:
                begin
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        vals_next[0] = nv_reg;
                        cnts_next[0] = '0;
                        for (int i = 1; i < LIST_DEPTH; i++)
                        begin
                            vals_next[i] = vals_reg[i-1];
                            cnts_next[i] = cnts_reg[i-1];
                        end
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                ACT_REM_FRONT:
                begin
                    if (empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        for (int i = 0; i < LIST_DEPTH - 1; i++)
                        begin
                            vals_next[i] = vals_reg[i+1];
                            cnts_next[i] = cnts_reg[i+1];
                        end
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                ACT_REM_BACK:
                begin
                    if (empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                ACT_READ:
                begin
                    if (!pos_ok)
                    begin
                        st_next = ST_RANGE;
                    end
                    else
                    begin
                        rv_next       = rd_val;
                        idx_next      = IDX_W'(pos_reg);
                        hold_val_next = rd_val;
                        hold_cnt_next = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
                    end
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end

        // bubble: pull predecessor back one cell, or drop the held entry in place
        if (dp_cmd.step)
        begin
            vals_next[idx_reg] = rd_val;
            cnts_next[idx_reg] = rd_cnt;
            idx_next           = idx_reg - IDX_W'(1);
        end
        if (dp_cmd.place)
        begin
            vals_next[idx_reg] = hold_val_reg;
            cnts_next[idx_reg] = hold_cnt_reg;
        end
    end

    assign occ_next = OCC_W'(fill_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            vals_reg[i] <= vals_next[i];
            cnts_reg[i] <= cnts_next[i];
        end
        idx_reg      <= idx_next;
        hold_val_reg <= hold_val_next;
        hold_cnt_reg <= hold_cnt_next;
        if (dp_cmd.load)
        begin
            op_reg  <= action_t'(action);
            nv_reg  <= new_value;
            pos_reg <= position;
        end
        if (dp_cmd.exec)
        begin
            rv_reg  <= rv_next;
            st_reg  <= st_next;
            occ_reg <= occ_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign status     = st_reg;
    assign occupancy  = occ_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LIST_DEPTH))
        else $error("fill level above list depth");

    a_step_dec: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.step |=> idx_reg == $past(idx_reg) - IDX_W'(1))
        else $error("bubble index did not move forward");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while still pending");
`endif

endmodule

FILE: rtl/count_ordered_self_organizing_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_ordered_self_organizing_list
// Bounded list of value/count entries; a read moves its entry ahead of entries with a lower access count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, new_value, position.
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   read_value, status and occupancy after the action.
//   The input beat is registered, then the action runs and registers the result beat.
//   Inserts, removes and rejected reads end there. An accepted read then
//   moves its entry forward past entries with a lower count and places it:
//   the move runs one cell per cycle over the entry row.
//   The next beat is taken once the move is done and the result register is
//   free or being drained in the same cycle.
//   Reset empties the list; entry contents are not cleared.
//   A stalled receiver holds the result; no input beat is taken meanwhile.
// ----------------------------------------------------------------------------
module count_ordered_self_organizing_list
    import cosol_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ACTION_W-1:0]   action,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [POS_W-1:0]      position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] read_value,
    output logic [STATUS_W-1:0]   status,
    output logic [OCC_W-1:0]      occupancy
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    cosol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    cosol_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .action     (action),
        .new_value  (new_value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule
